// ===== src/natpt_pkg.sv =====
// Package for the NAT port translation table: sizes, codes, payload and
// controller/datapath interface types. No dependencies.
`default_nettype none
package natpt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // Direction codes.
   localparam logic OP_OUTBOUND = 1'b0;
   localparam logic OP_INBOUND  = 1'b1;

   // Protocol codes.
   localparam logic [1:0] PROTO_TCP   = 2'd0;
   localparam logic [1:0] PROTO_UDP   = 2'd1;
   localparam logic [1:0] PROTO_ICMP  = 2'd2;
   localparam logic [1:0] PROTO_OTHER = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_HIT  = 2'd0;
   localparam logic [1:0] STATUS_NEW  = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   // Register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PUBLIC_ADDR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_BASE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TCP_TIMEOUT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UDP_TIMEOUT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ICMP_TIMEOUT = 3'd4;

   typedef struct packed {
      logic        opcode;
      logic [31:0] saddr;
      logic [31:0] daddr;
      logic [1:0]  proto;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_saddr;
      logic [31:0] out_daddr;
      logic [15:0] out_sport;
      logic [15:0] out_dport;
   } rsp_type;

   typedef struct packed {
      logic [31:0] local_addr;
      logic [31:0] remote_addr;
      logic [15:0] local_port;
      logic [15:0] remote_port;
      logic [15:0] global_port;
      logic [1:0]  proto;
      logic [31:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic start_walk;
      logic remove;
      logic advance;
      logic res_hit;
      logic res_full;
      logic start_search;
      logic search_step;
      logic insert;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_op;
      logic empty;
      logic op;
      logic expired;
      logic match;
      logic is_tail;
      logic full;
      logic slot_free;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// ===== src/nat_port_translation_table_core.sv =====
// NAT port translation table, top level: joins controller and datapath.
// Depends on natpt_pkg, natpt_ctrl and natpt_datapath.
//
// Use: a header word enters on req_valid/req_stall; one result word leaves
// on rsp_valid/rsp_stall for every request. Registers are written on the
// csr channel (csr_ready is always high); the user writes them only while
// the block is idle; the block itself does not enforce this. Each request
// is latched on acceptance, then each table entry visited in age order is
// read and evaluated (entry and link memories are read once per visit), an
// insertion adds a search of up to TABLE_ENTRIES slots, and the result is loaded.
// One request is processed at a time; req_stall is high from the cycle
// after acceptance until the result is loaded into the output register,
// so the next request is taken in the cycle after that load at the earliest.
// A result waiting under rsp_stall holds the block only once the next
// result is ready.
// Reset (synchronous) empties the table, clears the last given slot and
// restores the register defaults; no clearing pass is needed.
`default_nettype none
module nat_port_translation_table_core
   import natpt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   natpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   natpt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
`default_nettype wire

// ===== src/natpt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none
module natpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ===== src/natpt_datapath.sv =====
// Datapath: registers, entry and link memories, age list, matching and
// result register. Depends on natpt_pkg and natpt_ram.
`default_nettype none
module natpt_datapath
   import natpt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire req_type              req_data,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  wire cmd_type              cmd,
   output stat_type                  stat
);

   // Configuration registers.
   logic [31:0] public_addr_ff;
   logic [15:0] port_base_ff, tcp_timeout_ff, udp_timeout_ff, icmp_timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         public_addr_ff  <= '0;
         port_base_ff    <= 16'd49152;
         tcp_timeout_ff  <= 16'd300;
         udp_timeout_ff  <= 16'd60;
         icmp_timeout_ff <= 16'd30;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PUBLIC_ADDR:  public_addr_ff  <= csr_data;
            CSR_PORT_BASE:    port_base_ff    <= csr_data[15:0];
            CSR_TCP_TIMEOUT:  tcp_timeout_ff  <= csr_data[15:0];
            CSR_UDP_TIMEOUT:  udp_timeout_ff  <= csr_data[15:0];
            CSR_ICMP_TIMEOUT: icmp_timeout_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Latched request and working result.
   req_type req_ff;
   rsp_type res_ff, res_in;

   // Age list: a linked list of slots, oldest at the head.
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [SLOT_W-1:0]        head_ff, tail_ff, cur_ff, prev_ff, last_ff, ptr_ff;
   logic                     prev_valid_ff;

   entry_type         entry_q, entry_wdata;
   logic [SLOT_W-1:0] next_q, link_waddr, link_wdata;
   logic              link_we;

   natpt_ram #(.WIDTH($bits(entry_type)), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
      .clock (clock),
      .we    (cmd.insert),
      .waddr (ptr_ff),
      .wdata (entry_wdata),
      .raddr (cur_ff),
      .rdata (entry_q)
   );

   natpt_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (cur_ff),
      .rdata (next_q)
   );

   // Link writes: unlink on removal, append on insertion.
   always_comb begin
      link_we    = (cmd.remove && prev_valid_ff) || (cmd.insert && count_ff != '0);
      link_waddr = cmd.remove ? prev_ff : tail_ff;
      link_wdata = cmd.remove ? next_q : ptr_ff;
   end

   // New entry built from the request.
   logic [15:0] new_gport;
   always_comb begin
      new_gport = port_base_ff + 16'(ptr_ff);
      entry_wdata.local_addr  = req_ff.saddr;
      entry_wdata.remote_addr = req_ff.daddr;
      entry_wdata.local_port  = (req_ff.proto != PROTO_OTHER) ? req_ff.sport : 16'd0;
      entry_wdata.remote_port = (req_ff.proto == PROTO_TCP || req_ff.proto == PROTO_UDP) ?
                                req_ff.dport : 16'd0;
      entry_wdata.global_port = (req_ff.proto == PROTO_ICMP) ? req_ff.sport : new_gport;
      entry_wdata.proto       = req_ff.proto;
      entry_wdata.stamp       = req_ff.now_seconds;
   end

   // Expiry and match of the entry just read.
   logic        port_proto;
   logic [15:0] tmo;
   logic [31:0] age;
   logic        match_out, match_in;
   always_comb begin
      port_proto = (req_ff.proto == PROTO_TCP || req_ff.proto == PROTO_UDP);
      case (entry_q.proto)
         PROTO_TCP: tmo = tcp_timeout_ff;
         PROTO_UDP: tmo = udp_timeout_ff;
         default:   tmo = icmp_timeout_ff;
      endcase
      age = req_ff.now_seconds - entry_q.stamp;
      match_out = entry_q.local_addr == req_ff.saddr &&
                  entry_q.remote_addr == req_ff.daddr &&
                  entry_q.proto == req_ff.proto;
      match_in  = entry_q.remote_addr == req_ff.saddr && entry_q.proto == req_ff.proto;
      if (port_proto) begin
         match_out = match_out && entry_q.local_port == req_ff.sport &&
                     entry_q.remote_port == req_ff.dport;
         match_in  = match_in && entry_q.remote_port == req_ff.sport &&
                     entry_q.global_port == req_ff.dport;
      end else if (req_ff.proto == PROTO_ICMP) begin
         match_out = match_out && entry_q.local_port == req_ff.sport;
         match_in  = match_in && entry_q.global_port == req_ff.sport;
      end
      stat.req_op    = req_data.opcode;
      stat.empty     = count_ff == '0;
      stat.op        = req_ff.opcode;
      stat.expired   = req_ff.opcode == OP_OUTBOUND && entry_q.proto != PROTO_OTHER &&
                       age > {16'd0, tmo};
      stat.match     = (req_ff.opcode == OP_OUTBOUND) ? match_out : match_in;
      stat.is_tail   = cur_ff == tail_ff;
      stat.full      = count_ff == CNT_W'(TABLE_ENTRIES) && !stat.expired;
      stat.slot_free = !valid_ff[ptr_ff];
      stat.out_free  = !rsp_valid || !rsp_stall;
   end

   // Working result next value.
   always_comb begin
      res_in = res_ff;
      if (cmd.accept) begin
         res_in.status    = STATUS_MISS;
         res_in.out_saddr = req_data.saddr;
         res_in.out_daddr = req_data.daddr;
         res_in.out_sport = req_data.sport;
         res_in.out_dport = req_data.dport;
      end else if (cmd.res_hit) begin
         res_in.status = STATUS_HIT;
         if (req_ff.opcode == OP_OUTBOUND) begin
            res_in.out_saddr = public_addr_ff;
            if (port_proto) res_in.out_sport = entry_q.global_port;
         end else begin
            res_in.out_daddr = entry_q.local_addr;
            if (port_proto) res_in.out_dport = entry_q.local_port;
         end
      end else if (cmd.insert) begin
         res_in.status    = STATUS_NEW;
         res_in.out_saddr = public_addr_ff;
         if (port_proto) res_in.out_sport = new_gport;
      end else if (cmd.res_full) begin
         res_in.status = STATUS_FULL;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.accept) req_ff <= req_data;
   end

   // List and slot bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         count_ff      <= '0;
         last_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         cur_ff        <= '0;
         prev_ff       <= '0;
         ptr_ff        <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         if (cmd.start_walk) begin
            cur_ff        <= head_ff;
            prev_valid_ff <= 1'b0;
         end
         if (cmd.remove) begin
            valid_ff[cur_ff] <= 1'b0;
            count_ff         <= count_ff - 1'b1;
            cur_ff           <= next_q;
            if (!prev_valid_ff) head_ff <= next_q;
            if (cur_ff == tail_ff) tail_ff <= prev_ff;
         end
         if (cmd.advance) begin
            prev_ff       <= cur_ff;
            prev_valid_ff <= 1'b1;
            cur_ff        <= next_q;
         end
         if (cmd.start_search) ptr_ff <= last_ff + 1'b1;
         if (cmd.search_step)  ptr_ff <= ptr_ff + 1'b1;
         if (cmd.insert) begin
            valid_ff[ptr_ff] <= 1'b1;
            count_ff         <= count_ff + 1'b1;
            if (count_ff == '0) head_ff <= ptr_ff;
            tail_ff          <= ptr_ff;
            last_ff          <= ptr_ff;
         end
      end
   end

   // Output register: holds a finished word until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
      if (cmd.load_out) rsp_data <= res_ff;
   end

endmodule
`default_nettype wire

// ===== src/natpt_ctrl.sv =====
// Controller state machine: sequences the walk, the free-slot search and
// the result hand-off. Depends on natpt_pkg.
`default_nettype none
module natpt_ctrl
   import natpt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!stat.empty)                  state_in = ST_READ;
               else if (stat.req_op == OP_INBOUND) state_in = ST_FINISH;
               else                              state_in = ST_SEARCH;
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (!stat.expired && stat.match)      state_in = ST_FINISH;
            else if (!stat.is_tail)               state_in = ST_READ;
            else if (stat.op == OP_INBOUND || stat.full) state_in = ST_FINISH;
            else                                  state_in = ST_SEARCH;
         end
         ST_SEARCH: if (stat.slot_free) state_in = ST_FINISH;
         ST_FINISH: if (stat.out_free)  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = state_ff != ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept       = 1'b1;
               cmd.start_walk   = !stat.empty;
               cmd.start_search = stat.empty && stat.req_op == OP_OUTBOUND;
            end
         end
         ST_READ: ;
         ST_EVAL: begin
            if (stat.expired) begin
               cmd.remove = 1'b1;
            end else if (stat.match) begin
               cmd.res_hit = 1'b1;
            end else begin
               cmd.advance = 1'b1;
            end
            if ((stat.expired || !stat.match) && stat.is_tail && stat.op == OP_OUTBOUND) begin
               cmd.res_full     = stat.full;
               cmd.start_search = !stat.full;
            end
         end
         ST_SEARCH: begin
            cmd.insert      = stat.slot_free;
            cmd.search_step = !stat.slot_free;
         end
         ST_FINISH: cmd.load_out = stat.out_free;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== tb/nat_table_checker.sv =====
// Checker for the NAT port translation table: watches the request, result
// and register channels, predicts each result word and compares it.
// Depends on natpt_pkg.
`default_nettype none
module nat_table_checker
   import natpt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire req_type              req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rsp_type              rsp_data,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = TABLE_ENTRIES;

   // Shadow registers.
   logic [31:0] cfg_public;
   logic [15:0] cfg_base, tmo_tcp, tmo_udp, tmo_icmp;

   // Shadow table; a slot's port is in use exactly while the slot is valid.
   bit          tbl_valid [NSLOT];
   logic [31:0] tbl_local [NSLOT];
   logic [31:0] tbl_remote[NSLOT];
   logic [15:0] tbl_lport [NSLOT];
   logic [15:0] tbl_rport [NSLOT];
   logic [15:0] tbl_gport [NSLOT];
   logic [1:0]  tbl_proto [NSLOT];
   logic [31:0] tbl_stamp [NSLOT];
   logic [31:0] tbl_order [NSLOT];
   int          last_slot;
   logic [31:0] insert_count;

   rsp_type expected_words[$];

   // Restore the state that reset leaves.
   task automatic clear_table();
      cfg_public = '0;
      cfg_base = 16'd49152;
      tmo_tcp = 16'd300;
      tmo_udp = 16'd60;
      tmo_icmp = 16'd30;
      for (int s = 0; s < NSLOT; s++) begin
         tbl_valid[s] = 0;
      end
      last_slot = 0;
      insert_count = '0;
      expected_words.delete();
   endtask

   // Work out the translation of one header word, updating the table.
   function automatic rsp_type translate(req_type r);
      rsp_type     o;
      int          walk[NSLOT];
      int          n, k, e, hit, s;
      logic [31:0] age;
      logic [15:0] tmo;
      bit          same;
      n = 0;
      hit = -1;
      o.status = STATUS_MISS;
      o.out_saddr = r.saddr;
      o.out_daddr = r.daddr;
      o.out_sport = r.sport;
      o.out_dport = r.dport;

      // Valid slots, oldest insertion first.
      for (s = 0; s < NSLOT; s++) begin
         if (tbl_valid[s]) begin
            age = insert_count - tbl_order[s];
            k = n;
            while (k > 0 && (insert_count - tbl_order[walk[k-1]]) < age) begin
               walk[k] = walk[k-1];
               k--;
            end
            walk[k] = s;
            n++;
         end
      end

      if (r.opcode == OP_OUTBOUND) begin
         for (k = 0; k < n && hit < 0; k++) begin
            e = walk[k];
            tmo = (tbl_proto[e] == PROTO_TCP) ? tmo_tcp :
                  (tbl_proto[e] == PROTO_UDP) ? tmo_udp : tmo_icmp;
            if (tbl_proto[e] != PROTO_OTHER && (r.now_seconds - tbl_stamp[e]) > tmo) begin
               tbl_valid[e] = 0;
            end else begin
               same = tbl_local[e] == r.saddr && tbl_remote[e] == r.daddr &&
                      tbl_proto[e] == r.proto;
               if (r.proto == PROTO_TCP || r.proto == PROTO_UDP)
                  same = same && tbl_lport[e] == r.sport && tbl_rport[e] == r.dport;
               else if (r.proto == PROTO_ICMP)
                  same = same && tbl_lport[e] == r.sport;
               if (same)
                  hit = e;
            end
         end
         if (hit >= 0) begin
            o.status = STATUS_HIT;
         end else begin
            // Next free slot after the one given last.
            for (k = 1; k <= NSLOT && hit < 0; k++) begin
               s = (last_slot + k) % NSLOT;
               if (!tbl_valid[s])
                  hit = s;
            end
            if (hit < 0) begin
               o.status = STATUS_FULL;
            end else begin
               tbl_valid[hit] = 1;
               tbl_local[hit] = r.saddr;
               tbl_remote[hit] = r.daddr;
               tbl_lport[hit] = (r.proto == PROTO_OTHER) ? 16'd0 : r.sport;
               tbl_rport[hit] = (r.proto == PROTO_TCP || r.proto == PROTO_UDP) ?
                                r.dport : 16'd0;
               tbl_gport[hit] = (r.proto == PROTO_ICMP) ? r.sport :
                                cfg_base + 16'(hit);
               tbl_proto[hit] = r.proto;
               tbl_stamp[hit] = r.now_seconds;
               tbl_order[hit] = insert_count;
               insert_count++;
               last_slot = hit;
               o.status = STATUS_NEW;
            end
         end
         if (hit >= 0) begin
            o.out_saddr = cfg_public;
            if (r.proto == PROTO_TCP || r.proto == PROTO_UDP)
               o.out_sport = tbl_gport[hit];
         end
      end else begin
         for (k = 0; k < n && hit < 0; k++) begin
            e = walk[k];
            same = tbl_remote[e] == r.saddr && tbl_proto[e] == r.proto;
            if (r.proto == PROTO_TCP || r.proto == PROTO_UDP)
               same = same && tbl_rport[e] == r.sport && tbl_gport[e] == r.dport;
            else if (r.proto == PROTO_ICMP)
               same = same && tbl_gport[e] == r.sport;
            if (same)
               hit = e;
         end
         if (hit >= 0) begin
            o.status = STATUS_HIT;
            o.out_daddr = tbl_local[hit];
            if (r.proto == PROTO_TCP || r.proto == PROTO_UDP)
               o.out_dport = tbl_lport[hit];
         end
      end
      return o;
   endfunction

   // Signals only move at the rising edge, so the falling edge sees what
   // the next rising edge will take.
   always @(negedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_table();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PUBLIC_ADDR:  cfg_public = csr_data;
               CSR_PORT_BASE:    cfg_base = csr_data[15:0];
               CSR_TCP_TIMEOUT:  tmo_tcp = csr_data[15:0];
               CSR_UDP_TIMEOUT:  tmo_udp = csr_data[15:0];
               CSR_ICMP_TIMEOUT: tmo_icmp = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_words.push_back(translate(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: result word with none expected: %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: result word wrong, expected %p actual %p",
                           $time, want, rsp_data);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_words.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      clear_table();
   end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the NAT port translation table testbench: clock, reset, register
// settings and header words. Depends on natpt_pkg, the core and the checker.
`default_nettype none
module testbench
   import natpt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NFLOW = 96;

   typedef struct {
      logic [31:0] local_addr;
      logic [31:0] remote_addr;
      logic [1:0]  proto;
      logic [15:0] lport;
      logic [15:0] rport;
      logic [15:0] gport;
      bit          learned;
   } flow_type;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   rsp_type              rsp_data;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PUBLIC_ADDR;
   logic [31:0]          csr_data = '0;
   int                   fail_count, pending;

   flow_type    flows[NFLOW];
   int          flow_count;
   int          sent_flow_ids[$];
   logic [31:0] now_t;
   int          words_sent, full_seen, new_seen, hit_seen, miss_seen;
   int          stall_left;
   bit          quiet;

   nat_port_translation_table_core u_dut (.*);

   nat_table_checker u_checker (.*);

   always #10 clock = ~clock;

   // Receiver stalls: mostly short, a few long, none at all in quiet stretches.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if (!quiet && $urandom_range(0, 9) < 3) begin
         stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 2);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // Learn the global port of each flow from the results it gets.
   always @(negedge clock) begin
      int id;
      if (!reset && rsp_valid && !rsp_stall && sent_flow_ids.size() > 0) begin
         id = sent_flow_ids.pop_front();
         case (rsp_data.status)
            STATUS_HIT:  hit_seen++;
            STATUS_NEW:  new_seen++;
            STATUS_MISS: miss_seen++;
            default:     full_seen++;
         endcase
         if (id >= 0 && (rsp_data.status == STATUS_HIT || rsp_data.status == STATUS_NEW)) begin
            flows[id].gport = rsp_data.out_sport;
            flows[id].learned = 1;
         end
      end
   end

   // Present one header word after a random gap and wait until it is taken.
   task automatic send_word(req_type w, int flow_id);
      int gap;
      gap = quiet ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2));
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= w;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      sent_flow_ids.push_back(flow_id);
      words_sent++;
   endtask

   // Holds the write until it is taken; the caller drops csr_valid.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
   endtask

   // Let the block drain before touching its registers.
   task automatic wait_idle();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic req_type make_word(bit op, logic [31:0] sa, logic [31:0] da,
                                         logic [1:0] pr, logic [15:0] sp, logic [15:0] dp);
      req_type w;
      w.opcode = op;
      w.saddr = sa;
      w.daddr = da;
      w.proto = pr;
      w.sport = sp;
      w.dport = dp;
      w.now_seconds = now_t;
      return w;
   endfunction

   // A fresh set of flows drawn from a few hosts, so that matches recur.
   task automatic new_flows(int count);
      flow_count = count;
      for (int i = 0; i < count; i++) begin
         flows[i].local_addr = {24'h0a0000, 8'($urandom_range(0, 7))};
         flows[i].remote_addr = ($urandom_range(0, 3) == 0) ? $urandom :
                                {24'hc63364, 8'($urandom_range(0, 5))};
         flows[i].proto = 2'($urandom_range(0, 3));
         flows[i].lport = 16'($urandom);
         flows[i].rport = ($urandom_range(0, 1) == 0) ? 16'd443 : 16'($urandom);
         flows[i].learned = 0;
      end
   endtask

   // Time mostly creeps, sometimes jumps, now and then runs backwards.
   task automatic tick_time();
      case ($urandom_range(0, 49))
         0:       now_t = now_t - $urandom_range(1, 1000);
         1, 2:    now_t = now_t + $urandom_range(100, 70000);
         3:       now_t = $urandom;
         default: now_t = now_t + $urandom_range(0, 3);
      endcase
   endtask

   task automatic random_word();
      int       id, pick;
      bit       op;
      flow_type f;
      pick = $urandom_range(0, 99);
      id = $urandom_range(0, flow_count - 1);
      f = flows[id];
      tick_time();
      if (pick < 55) begin
         send_word(make_word(OP_OUTBOUND, f.local_addr, f.remote_addr, f.proto,
                             f.lport, f.rport), id);
      end else if (pick < 80) begin
         // Reply from the remote side, aimed at the learned global port.
         send_word(make_word(OP_INBOUND, f.remote_addr, $urandom, f.proto,
                             (f.proto == PROTO_ICMP) ? f.lport : f.rport,
                             f.learned ? f.gport : 16'($urandom)), -1);
      end else begin
         op = 1'($urandom_range(0, 1));
         send_word(make_word(op, $urandom, $urandom, 2'($urandom_range(0, 3)),
                             16'($urandom), 16'($urandom)), -1);
      end
   endtask

   task automatic apply_setting(logic [31:0] pub, logic [15:0] base, logic [15:0] t_tcp,
                                logic [15:0] t_udp, logic [15:0] t_icmp);
      wait_idle();
      write_reg(CSR_PUBLIC_ADDR, pub);
      write_reg(CSR_PORT_BASE, {16'hffff, base});
      write_reg(CSR_TCP_TIMEOUT, {16'hffff, t_tcp});
      write_reg(CSR_UDP_TIMEOUT, {16'h0000, t_udp});
      write_reg(CSR_ICMP_TIMEOUT, {16'h5555, t_icmp});
      csr_valid <= 0;
   endtask

   initial begin
      logic [31:0] ha, ra;
      words_sent = 0;
      full_seen = 0;
      new_seen = 0;
      hit_seen = 0;
      miss_seen = 0;
      stall_left = 0;
      quiet = 0;
      now_t = 32'd100;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed words at the reset settings.
      ha = 32'h0a000001;
      ra = 32'h5db8d822;
      send_word(make_word(OP_INBOUND, '0, '0, PROTO_TCP, '0, '0), -1);
      send_word(make_word(OP_OUTBOUND, ha, ra, PROTO_TCP, 16'd1234, 16'd80), -1);
      send_word(make_word(OP_OUTBOUND, ha, ra, PROTO_TCP, 16'd1234, 16'd80), -1);
      send_word(make_word(OP_INBOUND, ra, ha, PROTO_TCP, 16'd80, 16'd49153), -1);
      send_word(make_word(OP_INBOUND, ra, ha, PROTO_TCP, 16'd81, 16'd49153), -1);
      send_word(make_word(OP_OUTBOUND, '1, '1, PROTO_UDP, '1, '1), -1);
      send_word(make_word(OP_INBOUND, '1, '0, PROTO_UDP, '1, 16'd49154), -1);
      send_word(make_word(OP_OUTBOUND, ha, ra, PROTO_ICMP, 16'hffff, 16'h1111), -1);
      send_word(make_word(OP_INBOUND, ra, '1, PROTO_ICMP, 16'hffff, 16'h2222), -1);
      send_word(make_word(OP_OUTBOUND, ha, ra, PROTO_OTHER, 16'h7777, 16'h8888), -1);
      send_word(make_word(OP_INBOUND, ra, '0, PROTO_OTHER, 16'h0001, 16'h0002), -1);
      now_t = 32'd131;
      send_word(make_word(OP_OUTBOUND, ha, ra, PROTO_TCP, 16'd1234, 16'd80), -1);
      now_t = 32'd500;
      send_word(make_word(OP_OUTBOUND, ha, ra, PROTO_TCP, 16'd1234, 16'd80), -1);
      now_t = 32'd10;
      send_word(make_word(OP_OUTBOUND, ha, ra, PROTO_TCP, 16'd1234, 16'd80), -1);
      now_t = '1;
      send_word(make_word(OP_OUTBOUND, '0, '0, PROTO_UDP, '0, '0), -1);
      send_word(make_word(OP_INBOUND, '1, '1, PROTO_OTHER, '1, '1), -1);

      // Random words under a series of settings, extremes among them.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_setting($urandom, 16'd49152, 16'd300, 16'd60, 16'd30);
            1: apply_setting('1, 16'hffff, 16'd0, 16'd0, 16'd0);
            2: apply_setting('0, 16'd0, 16'hffff, 16'hffff, 16'hffff);
            3: apply_setting($urandom, 16'hffe0, 16'd20, 16'd10, 16'd5);
            4: apply_setting($urandom, 16'($urandom), 16'($urandom_range(0, 400)),
                             16'($urandom_range(0, 100)), 16'($urandom_range(0, 50)));
            default: apply_setting($urandom, 16'd1024, 16'd100, 16'd100, 16'd100);
         endcase
         new_flows((phase == 2) ? NFLOW : $urandom_range(8, 32));
         quiet = (phase == 4);
         repeat (305) random_word();
      end

      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      $display("Ran %0d header words through 6 register settings plus directed cases.",
               words_sent);
      $display("Results: %0d existing, %0d new, %0d no match, %0d table full.",
               hit_seen, new_seen, miss_seen, full_seen);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Ends a run that hangs.
   initial begin
      #100ms;
      $display("Timeout with %0d words sent and %0d results pending.", words_sent, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
